### rtl/core/prts_pkg.sv
// Package for the point rotate, translate and scale block.
// Holds the payload types, fixed widths, register indexes and the arctangent table.
// No dependencies.
package prts_pkg;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned CFG_W     = COORD_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned TRIG_W       = 32;
  localparam int unsigned Z_W          = 21;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);

  localparam int unsigned PROD_W    = COORD_W + TRIG_W;
  localparam int unsigned ROT_SHIFT = 30;
  localparam int unsigned ROT_W     = PROD_W + 1 - ROT_SHIFT;
  localparam int unsigned SUM_W     = ROT_W + 1;
  localparam int unsigned SPROD_W   = SUM_W + SCALE_W + 1;
  localparam int unsigned SCL_SHIFT = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
  } point_in_t;

  typedef struct packed {
    coord_t world_x;
    coord_t world_y;
    logic   saturated;
  } point_out_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] rot_x;
    logic signed [ROT_W-1:0] rot_y;
  } rot_t;

  // Arctangent of 2^-i in units of 1/2^20 turn.
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      4'd0:    val = 21'sd131072;
      4'd1:    val = 21'sd77376;
      4'd2:    val = 21'sd40884;
      4'd3:    val = 21'sd20753;
      4'd4:    val = 21'sd10417;
      4'd5:    val = 21'sd5213;
      4'd6:    val = 21'sd2607;
      4'd7:    val = 21'sd1304;
      4'd8:    val = 21'sd652;
      4'd9:    val = 21'sd326;
      4'd10:   val = 21'sd163;
      4'd11:   val = 21'sd81;
      4'd12:   val = 21'sd41;
      4'd13:   val = 21'sd20;
      4'd14:   val = 21'sd10;
      4'd15:   val = 21'sd5;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### rtl/core/prts_cordic.sv
// Iterative CORDIC that turns the rotation angle into cosine and sine in Q2.30.
// Runs one step per cycle after reset and after each start; depends on prts_pkg.
module prts_cordic import prts_pkg::*; #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ANGLE_W-1:0] angle_i,
  output trig_t              trig_o,
  output logic               busy_o
);

  localparam int unsigned DROP = ANGLE_W - ANGLE_BITS;
  localparam logic signed [TRIG_W-1:0] GAIN = 32'sd652032874;
  localparam logic signed [Z_W-1:0] QUARTER = 21'sd262144;
  localparam logic signed [Z_W-1:0] HALF    = 21'sd524288;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic                     load_q;
  logic                     run_q;
  logic [STEP_W-1:0]        step_q;
  logic signed [TRIG_W-1:0] x_q, y_q, x_d, y_d;
  logic signed [Z_W-1:0]    z_q, z_d, z_load;
  logic                     neg_q, neg_load;
  logic [ANGLE_W-1:0]       angle_m;
  logic signed [Z_W-2:0]    z_wrap;
  logic signed [Z_W-1:0]    z_ext;
  trig_t                    trig_q;

  always_comb begin
    angle_m  = (angle_i >> DROP) << DROP;
    z_wrap   = signed'({angle_m, 4'b0000});
    z_ext    = Z_W'(z_wrap);
    z_load   = z_ext;
    neg_load = 1'b0;
    if (z_ext > QUARTER) begin
      z_load   = z_ext - HALF;
      neg_load = 1'b1;
    end else if (z_ext < -QUARTER) begin
      z_load   = z_ext + HALF;
      neg_load = 1'b1;
    end
  end

  always_comb begin
    if (z_q >= 0) begin
      x_d = x_q - (y_q >>> step_q);
      y_d = y_q + (x_q >>> step_q);
      z_d = z_q - atan_lut(step_q);
    end else begin
      x_d = x_q + (y_q >>> step_q);
      y_d = y_q - (x_q >>> step_q);
      z_d = z_q + atan_lut(step_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b1;
      run_q  <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      load_q <= 1'b1;
      run_q  <= 1'b0;
    end else if (load_q) begin
      load_q <= 1'b0;
      run_q  <= 1'b1;
      step_q <= '0;
    end else if (run_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_q) begin
      x_q   <= GAIN;
      y_q   <= '0;
      z_q   <= z_load;
      neg_q <= neg_load;
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      if (step_q == LAST_STEP) begin
        trig_q.cos_v <= neg_q ? -x_d : x_d;
        trig_q.sin_v <= neg_q ? -y_d : y_d;
      end
    end
  end

  assign trig_o = trig_q;
  assign busy_o = load_q | run_q;

endmodule

### rtl/core/prts_rotate.sv
// Rotation stages: four products, then the rounded sums back to Q.8.
// Two register stages with valid and ready; depends on prts_pkg.
module prts_rotate import prts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  point_in_t in_data_i,
  input  trig_t     trig_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rot_t      out_data_o
);

  localparam logic signed [PROD_W:0] RND_ROT = (PROD_W + 1)'(2**(ROT_SHIFT - 1));

  logic                     va_q, vb_q;
  logic                     rdy_a, rdy_b;
  logic signed [PROD_W-1:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [PROD_W:0]   sum_x, sum_y;
  rot_t                     rot_q;

  assign rdy_b      = !vb_q || out_ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      pxc_q <= PROD_W'(in_data_i.point_x) * PROD_W'(trig_i.cos_v);
      pys_q <= PROD_W'(in_data_i.point_y) * PROD_W'(trig_i.sin_v);
      pxs_q <= PROD_W'(in_data_i.point_x) * PROD_W'(trig_i.sin_v);
      pyc_q <= PROD_W'(in_data_i.point_y) * PROD_W'(trig_i.cos_v);
    end
  end

  always_comb begin
    sum_x = (PROD_W + 1)'(pxc_q) - (PROD_W + 1)'(pys_q) + RND_ROT;
    sum_y = (PROD_W + 1)'(pxs_q) + (PROD_W + 1)'(pyc_q) + RND_ROT;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      rot_q.rot_x <= sum_x[PROD_W:ROT_SHIFT];
      rot_q.rot_y <= sum_y[PROD_W:ROT_SHIFT];
    end
  end

  assign out_valid_o = vb_q;
  assign out_data_o  = rot_q;

endmodule

### rtl/core/prts_scale.sv
// Translate and scale stages: offset add, scale product, rounding and saturation.
// Three register stages with valid and ready; depends on prts_pkg.
module prts_scale import prts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rot_t               in_data_i,
  input  coord_t             offset_x_i,
  input  coord_t             offset_y_i,
  input  logic [SCALE_W-1:0] scale_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output point_out_t         out_data_o
);

  localparam int unsigned W_W = SPROD_W - SCL_SHIFT;
  localparam logic signed [SPROD_W-1:0] RND_SCL = SPROD_W'(2**(SCL_SHIFT - 1));

  logic                      vc_q, vd_q, ve_q;
  logic                      rdy_c, rdy_d, rdy_e;
  logic signed [SUM_W-1:0]   sx_q, sy_q;
  logic signed [SPROD_W-1:0] px_q, py_q;
  logic signed [SPROD_W-1:0] rx_full, ry_full;
  logic signed [W_W-1:0]     wx, wy;
  logic signed [SCALE_W:0]   scale_s;
  logic                      hi_x, lo_x, hi_y, lo_y;
  point_out_t                res_d, res_q;

  assign rdy_e      = !ve_q || out_ready_i;
  assign rdy_d      = !vd_q || rdy_e;
  assign rdy_c      = !vc_q || rdy_d;
  assign in_ready_o = rdy_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_c) begin
        vc_q <= in_valid_i;
      end
      if (rdy_d) begin
        vd_q <= vc_q;
      end
      if (rdy_e) begin
        ve_q <= vd_q;
      end
    end
  end

  assign scale_s = signed'({1'b0, scale_i});

  always_ff @(posedge clk_i) begin
    if (rdy_c && in_valid_i) begin
      sx_q <= SUM_W'(in_data_i.rot_x) + SUM_W'(offset_x_i);
      sy_q <= SUM_W'(in_data_i.rot_y) + SUM_W'(offset_y_i);
    end
    if (rdy_d && vc_q) begin
      px_q <= SPROD_W'(sx_q) * SPROD_W'(scale_s);
      py_q <= SPROD_W'(sy_q) * SPROD_W'(scale_s);
    end
    if (rdy_e && vd_q) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    rx_full = px_q + RND_SCL;
    ry_full = py_q + RND_SCL;
    wx      = rx_full[SPROD_W-1:SCL_SHIFT];
    wy      = ry_full[SPROD_W-1:SCL_SHIFT];
    hi_x    = !wx[W_W-1] && (|wx[W_W-2:COORD_W-1]);
    lo_x    = wx[W_W-1] && !(&wx[W_W-2:COORD_W-1]);
    hi_y    = !wy[W_W-1] && (|wy[W_W-2:COORD_W-1]);
    lo_y    = wy[W_W-1] && !(&wy[W_W-2:COORD_W-1]);

    if (hi_x) begin
      res_d.world_x = {1'b0, {(COORD_W - 1){1'b1}}};
    end else if (lo_x) begin
      res_d.world_x = {1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      res_d.world_x = wx[COORD_W-1:0];
    end

    if (hi_y) begin
      res_d.world_y = {1'b0, {(COORD_W - 1){1'b1}}};
    end else if (lo_y) begin
      res_d.world_y = {1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      res_d.world_y = wy[COORD_W-1:0];
    end

    res_d.saturated = hi_x | lo_x | hi_y | lo_y;
  end

  assign out_valid_o = ve_q;
  assign out_data_o  = res_q;

endmodule

### rtl/core/point_rotate_translate_scale.sv
// Top level of the point rotate, translate and scale block.
// Holds the configuration registers and joins the sine/cosine unit and the pipeline.
// Depends on prts_pkg, prts_cordic, prts_rotate and prts_scale.
//
// Each point beat is rotated by the configured angle, offset by the node position
// and multiplied by the Q8.8 scale, with rounding and saturation to the coordinate
// range. The pipeline passes each point through the rotate and scale register stages
// and takes one per clock unless the output stalls or the CORDIC runs. Sine and
// cosine come from a 16-step CORDIC that runs once after reset and after each angle
// write; in_ready_o is low meanwhile. Offset and scale writes take effect at once.
module point_rotate_translate_scale import prts_pkg::*; #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  point_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output point_out_t           out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [ANGLE_W-1:0] angle_q;
  coord_t             offset_x_q, offset_y_q;
  logic [SCALE_W-1:0] scale_q;
  logic               angle_wr;
  logic               cordic_busy;
  trig_t              trig;
  logic               rot_in_valid, rot_in_ready;
  logic               rot_valid, rot_ready;
  rot_t               rot_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q    <= '0;
      offset_x_q <= '0;
      offset_y_q <= '0;
      scale_q    <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ANGLE:    angle_q    <= cfg_data_i[ANGLE_W-1:0];
        REG_OFFSET_X: offset_x_q <= cfg_data_i[COORD_W-1:0];
        REG_OFFSET_Y: offset_y_q <= cfg_data_i[COORD_W-1:0];
        REG_SCALE:    scale_q    <= cfg_data_i[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign angle_wr = cfg_we_i && (cfg_index_i == REG_ANGLE);

  prts_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (angle_wr),
    .angle_i (angle_q),
    .trig_o  (trig),
    .busy_o  (cordic_busy)
  );

  assign rot_in_valid = in_valid_i && !cordic_busy;
  assign in_ready_o   = rot_in_ready && !cordic_busy;

  prts_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_in_valid),
    .in_ready_o  (rot_in_ready),
    .in_data_i   (in_data_i),
    .trig_i      (trig),
    .out_valid_o (rot_valid),
    .out_ready_i (rot_ready),
    .out_data_o  (rot_data)
  );

  prts_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_valid),
    .in_ready_o  (rot_ready),
    .in_data_i   (rot_data),
    .offset_x_i  (offset_x_q),
    .offset_y_i  (offset_y_q),
    .scale_i     (scale_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sim/prts_world_point_checker.sv
`timescale 1ns / 100ps
// Checker for the point rotate, translate and scale block: predicts each world point
// beat from the accepted local point and the tracked registers, and compares results.
// Depends on prts_pkg.
module prts_world_point_checker import prts_pkg::*; #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  point_in_t            in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  point_out_t           out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  localparam longint CORDIC_GAIN = 652032874;
  localparam longint TURN_QUARTER = 262144;
  localparam longint TURN_HALF = 524288;
  localparam longint TURN_FULL = 1048576;
  localparam longint ROT_ROUND = 536870912;
  localparam longint SCALE_ROUND = 128;
  localparam longint COORD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;

  longint arctan_turns [CORDIC_STEPS] = '{
    131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
    652, 326, 163, 81, 41, 20, 10, 5
  };

  logic [ANGLE_W-1:0] cur_angle;
  longint             cur_off_x;
  longint             cur_off_y;
  longint             cur_scale;
  point_out_t         world_queue [$];
  int                 mismatches = 0;

  task automatic cordic_sin_cos(input logic [ANGLE_W-1:0] angle,
                                output longint cos_q30, output longint sin_q30);
    logic [ANGLE_W-1:0] kept;
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     negate;
    int     i;
    kept = (angle >> (ANGLE_W - ANGLE_BITS)) << (ANGLE_W - ANGLE_BITS);
    z = longint'(kept);
    z = z * 16;
    x = CORDIC_GAIN;
    y = 0;
    negate = 1'b0;
    if (z >= TURN_HALF) z = z - TURN_FULL;
    if (z > TURN_QUARTER) begin
      z = z - TURN_HALF;
      negate = 1'b1;
    end else if (z < -TURN_QUARTER) begin
      z = z + TURN_HALF;
      negate = 1'b1;
    end
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_turns[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_turns[i];
      end
    end
    cos_q30 = negate ? -x : x;
    sin_q30 = negate ? -y : y;
  endtask

  function automatic longint clip_coord(input longint v, inout bit clipped);
    if (v > COORD_HI) begin
      clipped = 1'b1;
      return COORD_HI;
    end
    if (v < COORD_LO) begin
      clipped = 1'b1;
      return COORD_LO;
    end
    return v;
  endfunction

  task automatic predict_world_point(input point_in_t p, output point_out_t w);
    longint c;
    longint s;
    longint px;
    longint py;
    longint rx;
    longint ry;
    longint wx;
    longint wy;
    bit     clipped;
    cordic_sin_cos(cur_angle, c, s);
    px = longint'(p.point_x);
    py = longint'(p.point_y);
    rx = (px * c - py * s + ROT_ROUND) >>> 30;
    ry = (px * s + py * c + ROT_ROUND) >>> 30;
    wx = ((rx + cur_off_x) * cur_scale + SCALE_ROUND) >>> 8;
    wy = ((ry + cur_off_y) * cur_scale + SCALE_ROUND) >>> 8;
    clipped = 1'b0;
    wx = clip_coord(wx, clipped);
    wy = clip_coord(wy, clipped);
    w.world_x = wx[COORD_W-1:0];
    w.world_y = wy[COORD_W-1:0];
    w.saturated = clipped;
  endtask

  always @(posedge clk_i) begin : monitor
    point_out_t want;
    point_out_t got;
    if (!rst_ni) begin
      cur_angle = '0;
      cur_off_x = 0;
      cur_off_y = 0;
      cur_scale = longint'(SCALE_RESET);
      world_queue.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (world_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected world point beat x=%0d y=%0d sat=%0b",
                     $time, got.world_x, got.world_y, got.saturated);
        end else begin
          want = world_queue.pop_front();
          if (got.world_x !== want.world_x || got.world_y !== want.world_y ||
              got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: world point mismatch: expected x=%0d y=%0d sat=%0b,",
                       $time, want.world_x, want.world_y, want.saturated,
                       " got x=%0d y=%0d sat=%0b",
                       got.world_x, got.world_y, got.saturated);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_world_point(in_data_i, want);
        world_queue = {world_queue, want};
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ANGLE:    cur_angle = cfg_data_i[ANGLE_W-1:0];
          REG_OFFSET_X: cur_off_x = longint'(coord_t'(cfg_data_i));
          REG_OFFSET_Y: cur_off_y = longint'(coord_t'(cfg_data_i));
          REG_SCALE:    cur_scale = longint'(cfg_data_i[SCALE_W-1:0]);
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    pending_o <= world_queue.size();
  end

endmodule

### sim/point_rotate_translate_scale_test.sv
`timescale 1ns / 100ps
// Testbench top for the point rotate, translate and scale block: drives point beats and
// register writes, idles both channels at random and gives the verdict.
// Depends on prts_pkg, the block and prts_world_point_checker.
module point_rotate_translate_scale_test;
  import prts_pkg::*;

  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned RANDOM_PHASES = 25;
  localparam int unsigned POINTS_PER_PHASE = 70;
  localparam int unsigned HOLD_PHASE = 2;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned STALL_LIMIT = 2000;

  localparam coord_t COORD_MAX = coord_t'((1 << (COORD_W - 1)) - 1);
  localparam coord_t COORD_MIN = ~COORD_MAX;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;
  localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 16'hC000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  point_in_t            in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  point_out_t           out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  int          mismatch_count;
  int          pending_count;
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  point_rotate_translate_scale #(
    .ANGLE_BITS(ANGLE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  prts_world_point_checker #(
    .ANGLE_BITS(ANGLE_BITS)
  ) world_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  function automatic coord_t pick_coord();
    coord_t      c;
    int unsigned v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: c = COORD_MAX;
          1: c = COORD_MIN;
          2: c = '0;
          default: c = '1;
        endcase
      end
      1, 2: c = coord_t'($urandom);
      default: begin
        v = $urandom_range(0, 1 << 17);
        c = coord_t'(v) - coord_t'(1 << 16);
      end
    endcase
    return c;
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [ANGLE_W-1:0] a;
    a = ANGLE_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 6))
        0: a = '0;
        1: a = QUARTER_TURN;
        2: a = HALF_TURN;
        3: a = THREE_QUARTER_TURN;
        4: a = QUARTER_TURN + 1'b1;
        5: a = HALF_TURN - 1'b1;
        default: a = '1;
      endcase
    end
    return a;
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    logic [SCALE_W-1:0] s;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = 1;
          2: s = SCALE_RESET;
          default: s = '1;
        endcase
      end
      1: s = SCALE_W'($urandom);
      default: s = SCALE_W'($urandom_range(64, 1024));
    endcase
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // The 16-bit registers get random upper bits, which the block must ignore.
  task automatic load_config(input logic [ANGLE_W-1:0] angle, input coord_t off_x,
                             input coord_t off_y, input logic [SCALE_W-1:0] scale);
    logic [CFG_W-1:0] word;
    word = CFG_W'($urandom);
    word[ANGLE_W-1:0] = angle;
    write_reg(REG_ANGLE, word);
    write_reg(REG_OFFSET_X, off_x);
    write_reg(REG_OFFSET_Y, off_y);
    word = CFG_W'($urandom);
    word[SCALE_W-1:0] = scale;
    write_reg(REG_SCALE, word);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_point(input coord_t x, input coord_t y);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{point_x: x, point_y: y};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned stall;
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 6);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers at their reset values.
    send_point('0, '0);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN);
    send_point(1, -1);
    send_point(-256, 256);

    // Half turn with extreme offsets and scale, saturating both ways.
    wait_idle();
    load_config(HALF_TURN, COORD_MAX, COORD_MIN, '1);
    send_point('0, '0);
    send_point(256, -256);
    send_point(COORD_MIN, COORD_MAX);

    // Exact quarter turn with zero scale.
    wait_idle();
    load_config(QUARTER_TURN, '0, '0, '0);
    send_point(COORD_MAX, COORD_MIN);
    send_point(1, 1);

    // Just past a quarter turn, so the angle folds by a half turn.
    wait_idle();
    load_config(QUARTER_TURN + 1'b1, -1, 1, 1);
    send_point(COORD_MAX, COORD_MAX);
    send_point(-1, -1);

    wait_idle();
    load_config('1, COORD_MIN, COORD_MAX, SCALE_RESET);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX);
    send_point('0, '0);

    wait_idle();
    load_config(THREE_QUARTER_TURN, 1000, -1000, SCALE_RESET + 1'b1);
    send_point(12345, -6789);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      load_config(pick_angle(), pick_coord(), pick_coord(), pick_scale());
      steady = ($urandom_range(0, 3) == 0) || (phase == HOLD_PHASE);
      if (phase == HOLD_PHASE) hold_request = 1'b1;
      for (n = 0; n < POINTS_PER_PHASE; n++) send_point(pick_coord(), pick_coord());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
